FILE: rtl/nep_pkg.sv
// Package for the note envelope phase and rate block.
// Holds shared widths, reset values, register indexes and the phase code.
// Depends on nothing.
package nep_pkg;

  localparam int TIME_BITS_DEF = 32;
  localparam int RATE_FRAC_DEF = 15;

  localparam int DUR_W    = 16;  // configured phase lengths
  localparam int FIT_W    = 18;  // fitted phase lengths, below 2 * (2^16 + 2^16)
  localparam int RATE_W   = 16;
  localparam int PHASE_W  = 2;
  localparam int SHARE_W  = 4;   // shares and bases in tenths
  localparam int CFG_IDX_W = 8;

  localparam logic [DUR_W-1:0] DECAY_RESET   = 16'd100;
  localparam logic [DUR_W-1:0] RELEASE_RESET = 16'd250;

  localparam logic [CFG_IDX_W-1:0] REG_DECAY   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE = 8'd1;

  localparam logic [SHARE_W-1:0] TENTHS_ALL = 4'd10;

  typedef enum logic [PHASE_W-1:0] {
    PH_DECAY   = 2'd0,
    PH_SUSTAIN = 2'd1,
    PH_RELEASE = 2'd2
  } phase_e;

endpackage

FILE: rtl/nep_ifs.sv
// Channel interfaces of the note envelope phase and rate block.
// Depends on nep_pkg for field widths.
interface nep_note_if import nep_pkg::*; #(
  parameter int TIME_BITS = TIME_BITS_DEF
);
  logic                 valid;
  logic                 ready;
  logic [TIME_BITS-1:0] play_time;
  logic [TIME_BITS-1:0] note_start;
  logic [TIME_BITS-1:0] note_end;
  modport source (output valid, play_time, note_start, note_end, input ready);
  modport sink   (input valid, play_time, note_start, note_end, output ready);
endinterface

interface nep_key_if import nep_pkg::*;;
  logic               valid;
  logic               ready;
  logic [RATE_W-1:0]  key_rate;
  logic [PHASE_W-1:0] key_phase;
  modport source (output valid, key_rate, key_phase, input ready);
  modport sink   (input valid, key_rate, key_phase, output ready);
endinterface

interface nep_cfg_if import nep_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [DUR_W-1:0]     data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/nep_front.sv
// Front end: range checks, fitting of decay and release lengths, phase selection.
// Three register stages. Depends on nep_pkg.
module nep_front import nep_pkg::*; #(
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [DUR_W-1:0]     decay_len_i,
  input  logic [DUR_W-1:0]     release_len_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [TIME_BITS-1:0] play_i,
  input  logic [TIME_BITS-1:0] start_i,
  input  logic [TIME_BITS-1:0] end_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output phase_e               phase_o,
  output logic [SHARE_W-1:0]   base_o,
  output logic [SHARE_W-1:0]   share_o,
  output logic [TIME_BITS-1:0] num_o,
  output logic [TIME_BITS-1:0] den_o
);
  localparam int TB = TIME_BITS;
  localparam int W  = ((TB > FIT_W) ? TB : FIT_W) + 2;

  logic va_q, vb_q, vc_q;
  logic rdy_a, rdy_b, rdy_c;

  assign rdy_c = !vc_q || out_ready_i;
  assign rdy_b = !vb_q || rdy_c;
  assign rdy_a = !va_q || rdy_b;
  assign in_ready_o = rdy_a;

  // Stage A: note length, offset, outside test and the midpoint.
  logic [TB-1:0] a_len_d, a_off_d, a_mid_d;
  logic          a_out_d;
  logic [TB-1:0] a_len_q, a_off_q, a_mid_q, a_start_q, a_end_q;
  logic          a_out_q;
  logic [TB:0]   sum_sd;
  logic [TB-1:0] end_r;

  always_comb begin
    a_out_d = (start_i > end_i) || (play_i > end_i) || (play_i < start_i);
    a_len_d = end_i - start_i;
    a_off_d = play_i - start_i;
    sum_sd  = {1'b0, start_i} + {{(TB+1-DUR_W){1'b0}}, decay_len_i};
    end_r   = end_i - {{(TB-DUR_W){1'b0}}, release_len_i};
    a_mid_d = sum_sd[TB:1] + {1'b0, end_r[TB-1:1]};
  end

  // Stage B: fit the lengths to the note.
  logic [FIT_W-1:0]   b_d_d, b_r_d;
  logic [SHARE_W-1:0] b_sdec_d, b_ssus_d;
  logic               b_wrap_d;
  logic [TB-1:0]      b_len_q, b_off_q;
  logic               b_out_q;
  logic [FIT_W-1:0]   b_d_q, b_r_q;
  logic [SHARE_W-1:0] b_sdec_q, b_ssus_q;
  logic [W-1:0]       len_w, d_w, dr_w;
  logic [TB-1:0]      dm, rm, lmd;

  always_comb begin
    len_w = W'(a_len_q);
    d_w   = W'(decay_len_i);
    dr_w  = W'(decay_len_i) + W'(release_len_i);
    dm    = a_mid_q - a_start_q;
    rm    = a_end_q - a_mid_q;
    lmd   = a_len_q - TB'(decay_len_i);
    b_d_d    = FIT_W'(decay_len_i);
    b_r_d    = FIT_W'(release_len_i);
    b_sdec_d = 4'd3;
    b_ssus_d = 4'd4;
    b_wrap_d = 1'b0;
    priority if (len_w < d_w) begin
    end else if (len_w < dr_w) begin
      b_r_d    = FIT_W'(lmd);
      b_sdec_d = 4'd5;
      b_ssus_d = 4'd0;
    end else if (len_w < {dr_w[W-2:0], 1'b0}) begin
      b_d_d    = FIT_W'(dm);
      b_r_d    = FIT_W'(rm);
      b_sdec_d = 4'd5;
      b_ssus_d = 4'd0;
      // With no decay and an odd start the rounded midpoint can fall just
      // before the start; the decay length then wraps to a huge value and
      // the rate of the decay phase is zero, as for a note outside its span.
      b_wrap_d = (a_mid_q < a_start_q);
    end
  end

  // Stage C: choose the phase and the operands of the scaled quotient.
  phase_e             c_ph_d, c_ph_q;
  logic [SHARE_W-1:0] c_base_d, c_share_d, c_base_q, c_share_q;
  logic [TB-1:0]      c_num_d, c_den_d, c_num_q, c_den_q;
  logic [W-1:0]       l_w, o_w, fd_w, fr_w, lr_w, span_w;

  always_comb begin
    l_w    = W'(b_len_q);
    o_w    = W'(b_off_q);
    fd_w   = W'(b_d_q);
    fr_w   = W'(b_r_q);
    lr_w   = l_w - fr_w;
    span_w = l_w - fd_w - fr_w;
    c_ph_d    = PH_DECAY;
    c_base_d  = '0;
    c_share_d = '0;
    c_num_d   = '0;
    c_den_d   = TB'(1);
    priority if (b_out_q) begin
    end else if (o_w < fd_w) begin
      if (b_d_q != '0) begin
        c_share_d = b_sdec_q;
        c_num_d   = b_off_q;
        c_den_d   = TB'(b_d_q);
      end
    end else if ((l_w >= fr_w) && (o_w <= lr_w)) begin
      c_ph_d = PH_SUSTAIN;
      if (span_w != '0) begin
        c_base_d  = b_sdec_q;
        c_share_d = b_ssus_q;
        c_num_d   = TB'(o_w - fd_w);
        c_den_d   = TB'(span_w);
      end else begin
        c_base_d = b_sdec_q + b_ssus_q;
      end
    end else begin
      c_ph_d = PH_RELEASE;
      if ((b_r_q == '0) || (l_w < fr_w)) begin
        c_base_d = TENTHS_ALL;
      end else begin
        c_base_d  = b_sdec_q + b_ssus_q;
        c_share_d = TENTHS_ALL - b_sdec_q - b_ssus_q;
        c_num_d   = TB'(o_w - lr_w);
        c_den_d   = TB'(b_r_q);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else begin
      if (rdy_a) va_q <= in_valid_i;
      if (rdy_b) vb_q <= va_q;
      if (rdy_c) vc_q <= vb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_a && in_valid_i) begin
      a_len_q   <= a_len_d;
      a_off_q   <= a_off_d;
      a_out_q   <= a_out_d;
      a_mid_q   <= a_mid_d;
      a_start_q <= start_i;
      a_end_q   <= end_i;
    end
    if (rdy_b && va_q) begin
      b_len_q  <= a_len_q;
      b_off_q  <= a_off_q;
      b_out_q  <= a_out_q || b_wrap_d;
      b_d_q    <= b_d_d;
      b_r_q    <= b_r_d;
      b_sdec_q <= b_sdec_d;
      b_ssus_q <= b_ssus_d;
    end
    if (rdy_c && vb_q) begin
      c_ph_q    <= c_ph_d;
      c_base_q  <= c_base_d;
      c_share_q <= c_share_d;
      c_num_q   <= c_num_d;
      c_den_q   <= c_den_d;
    end
  end

  assign out_valid_o = vc_q;
  assign phase_o     = c_ph_q;
  assign base_o      = c_base_q;
  assign share_o     = c_share_q;
  assign num_o       = c_num_q;
  assign den_o       = c_den_q;
endmodule

FILE: rtl/nep_div.sv
// Pipelined restoring divider: floor(share * 2^F * num / den), one quotient bit a stage.
// Depends on nep_pkg.
module nep_div import nep_pkg::*; #(
  parameter int TIME_BITS      = TIME_BITS_DEF,
  parameter int RATE_FRAC_BITS = RATE_FRAC_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  phase_e                      phase_i,
  input  logic [SHARE_W-1:0]          base_i,
  input  logic [SHARE_W-1:0]          share_i,
  input  logic [TIME_BITS-1:0]        num_i,
  input  logic [TIME_BITS-1:0]        den_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output phase_e                      phase_o,
  output logic [SHARE_W-1:0]          base_o,
  output logic [RATE_FRAC_BITS+3:0]   quot_o
);
  localparam int TB = TIME_BITS;
  localparam int QB = RATE_FRAC_BITS + SHARE_W;
  localparam int NS = QB + 1;

  logic               v_q   [NS];
  logic               rdy   [NS+1];
  logic [TB-1:0]      rem_q [NS];
  logic [TB-1:0]      den_q [NS];
  logic [QB-1:0]      lo_q  [NS];
  logic [QB-1:0]      quo_q [NS];
  phase_e             ph_q  [NS];
  logic [SHARE_W-1:0] base_q[NS];

  logic [TB+SHARE_W-1:0] prod;
  assign prod = {{SHARE_W{1'b0}}, num_i} * {{TB{1'b0}}, share_i};

  assign rdy[NS]    = out_ready_i;
  assign in_ready_o = rdy[0];

  for (genvar k = 0; k < NS; k++) begin : g_stage
    assign rdy[k] = !v_q[k] || rdy[k+1];

    logic               vin;
    logic [TB-1:0]      rem_d, den_d;
    logic [QB-1:0]      lo_d, quo_d;
    phase_e             ph_d;
    logic [SHARE_W-1:0] base_d;

    if (k == 0) begin : g_first
      // The numerator's upper part seeds the remainder; it is already below den.
      always_comb begin
        vin    = in_valid_i;
        rem_d  = prod[TB+SHARE_W-1:SHARE_W];
        lo_d   = {prod[SHARE_W-1:0], {RATE_FRAC_BITS{1'b0}}};
        quo_d  = '0;
        den_d  = den_i;
        ph_d   = phase_i;
        base_d = base_i;
      end
    end else begin : g_step
      logic [TB:0] t;
      logic        ge;
      always_comb begin
        vin    = v_q[k-1];
        t      = {rem_q[k-1], lo_q[k-1][QB-1]};
        ge     = t >= {1'b0, den_q[k-1]};
        rem_d  = ge ? TB'(t - {1'b0, den_q[k-1]}) : t[TB-1:0];
        lo_d   = {lo_q[k-1][QB-2:0], 1'b0};
        quo_d  = {quo_q[k-1][QB-2:0], ge};
        den_d  = den_q[k-1];
        ph_d   = ph_q[k-1];
        base_d = base_q[k-1];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (rdy[k]) begin
        v_q[k] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[k] && vin) begin
        rem_q[k]  <= rem_d;
        lo_q[k]   <= lo_d;
        quo_q[k]  <= quo_d;
        den_q[k]  <= den_d;
        ph_q[k]   <= ph_d;
        base_q[k] <= base_d;
      end
    end
  end

  assign out_valid_o = v_q[NS-1];
  assign phase_o     = ph_q[NS-1];
  assign base_o      = base_q[NS-1];
  assign quot_o      = quo_q[NS-1];
endmodule

FILE: rtl/nep_scale.sv
// Final scaling: floor((base * 2^F + quotient) / 10) by reciprocal multiply and one correction.
// Three register stages, the last one is the output register. Depends on nep_pkg.
module nep_scale import nep_pkg::*; #(
  parameter int RATE_FRAC_BITS = RATE_FRAC_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  phase_e                    phase_i,
  input  logic [SHARE_W-1:0]        base_i,
  input  logic [RATE_FRAC_BITS+3:0] quot_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [RATE_W-1:0]         rate_o,
  output phase_e                    phase_o
);
  localparam int QB = RATE_FRAC_BITS + SHARE_W;
  localparam logic [QB-1:0] RECIP = QB'((2 ** QB) / 10);

  logic v0_q, v1_q, v2_q;
  logic rdy0, rdy1, rdy2;
  assign rdy2 = !v2_q || out_ready_i;
  assign rdy1 = !v1_q || rdy2;
  assign rdy0 = !v0_q || rdy1;
  assign in_ready_o = rdy0;

  logic [QB-1:0]   x_d, x0_q, x1_q, q1_d, q1_q, q2_d;
  logic [2*QB-1:0] prod;
  logic [QB+3:0]   back;
  logic [QB+3:0]   rem;
  phase_e          ph0_q, ph1_q, ph2_q;
  logic [RATE_W-1:0] rate_q;

  always_comb begin
    x_d  = {base_i, {RATE_FRAC_BITS{1'b0}}} + quot_i;
    prod = {{QB{1'b0}}, x0_q} * {{QB{1'b0}}, RECIP};
    q1_d = prod[2*QB-1:QB];
    back = {4'b0, q1_q} * (QB+4)'(10);
    rem  = {4'b0, x1_q} - back;
    q2_d = (rem >= (QB+4)'(10)) ? q1_q + QB'(1) : q1_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (rdy0) v0_q <= in_valid_i;
      if (rdy1) v1_q <= v0_q;
      if (rdy2) v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy0 && in_valid_i) begin
      x0_q  <= x_d;
      ph0_q <= phase_i;
    end
    if (rdy1 && v0_q) begin
      x1_q  <= x0_q;
      q1_q  <= q1_d;
      ph1_q <= ph0_q;
    end
    if (rdy2 && v1_q) begin
      rate_q <= RATE_W'(q2_d);
      ph2_q  <= ph1_q;
    end
  end

  assign out_valid_o = v2_q;
  assign rate_o      = rate_q;
  assign phase_o     = ph2_q;
endmodule

FILE: rtl/note_envelope_phase_rate.sv
// Top level of the note envelope phase and rate block.
// Depends on nep_pkg, nep_ifs, nep_front, nep_div and nep_scale.
//
//   channel   direction   payload                                 accepted when
//   cfg_i     in          index, data (16 bit length in ms)       valid && ready
//   note_i    in          play_time, note_start, note_end         valid && ready
//   key_o     out         key_rate (Q1.F), key_phase              valid && ready
//
// One request enters every cycle while key_o is not stalled. The pipeline has three front
// stages, one multiply stage plus one restoring divider stage per quotient bit, and three
// scaling stages ending in the output register.
// Reset clears all valid bits and loads decay 100 ms and release 250 ms.
// Each stage holds its request while the next one is full and stalled, so a
// stall at key_o fills the empty stages first before note_i.ready drops.
module note_envelope_phase_rate import nep_pkg::*; #(
  parameter int TIME_BITS      = TIME_BITS_DEF,
  parameter int RATE_FRAC_BITS = RATE_FRAC_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  nep_cfg_if.sink  cfg_i,
  nep_note_if.sink note_i,
  nep_key_if.source key_o
);
  localparam int QB = RATE_FRAC_BITS + SHARE_W;

  // Configuration registers. Writes are accepted at once. The user must issue them only
  // while the pipeline is empty (the block does not enforce it); the stages read them directly.
  logic [DUR_W-1:0] decay_q, release_q;
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      decay_q   <= DECAY_RESET;
      release_q <= RELEASE_RESET;
    end else if (cfg_i.valid) begin
      if (cfg_i.index == REG_DECAY)   decay_q   <= cfg_i.data;
      if (cfg_i.index == REG_RELEASE) release_q <= cfg_i.data;
    end
  end

  logic                 f_valid, f_ready;
  phase_e               f_phase;
  logic [SHARE_W-1:0]   f_base, f_share;
  logic [TIME_BITS-1:0] f_num, f_den;

  nep_front #(.TIME_BITS(TIME_BITS)) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .decay_len_i   (decay_q),
    .release_len_i (release_q),
    .in_valid_i    (note_i.valid),
    .in_ready_o    (note_i.ready),
    .play_i        (note_i.play_time),
    .start_i       (note_i.note_start),
    .end_i         (note_i.note_end),
    .out_valid_o   (f_valid),
    .out_ready_i   (f_ready),
    .phase_o       (f_phase),
    .base_o        (f_base),
    .share_o       (f_share),
    .num_o         (f_num),
    .den_o         (f_den)
  );

  logic               d_valid, d_ready;
  phase_e             d_phase;
  logic [SHARE_W-1:0] d_base;
  logic [QB-1:0]      d_quot;

  nep_div #(.TIME_BITS(TIME_BITS), .RATE_FRAC_BITS(RATE_FRAC_BITS)) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (f_valid),
    .in_ready_o  (f_ready),
    .phase_i     (f_phase),
    .base_i      (f_base),
    .share_i     (f_share),
    .num_i       (f_num),
    .den_i       (f_den),
    .out_valid_o (d_valid),
    .out_ready_i (d_ready),
    .phase_o     (d_phase),
    .base_o      (d_base),
    .quot_o      (d_quot)
  );

  phase_e s_phase;

  nep_scale #(.RATE_FRAC_BITS(RATE_FRAC_BITS)) u_scale (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (d_valid),
    .in_ready_o  (d_ready),
    .phase_i     (d_phase),
    .base_i      (d_base),
    .quot_i      (d_quot),
    .out_valid_o (key_o.valid),
    .out_ready_i (key_o.ready),
    .rate_o      (key_o.key_rate),
    .phase_o     (s_phase)
  );

  assign key_o.key_phase = s_phase;

  // Input backpressure only ever comes from a stalled result at the output.
  a_stall_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !note_i.ready |-> (key_o.valid && !key_o.ready))
    else $error("input stalled without an output stall");

  // A result never exceeds 1.0 when the rate fits its 16 bits.
  a_rate_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (key_o.valid && (RATE_FRAC_BITS <= 15)) |->
      (32'(key_o.key_rate) <= (32'd1 << RATE_FRAC_BITS)))
    else $error("rate above 1.0");

  // The decay share is at most half, so a decay result stays at or below 0.5.
  a_decay_half: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (key_o.valid && (key_o.key_phase == PH_DECAY) && (RATE_FRAC_BITS <= 15)) |->
      (32'(key_o.key_rate) <= (32'd1 << (RATE_FRAC_BITS - 1))))
    else $error("decay rate above one half");
endmodule
